[design/l3d_pkg.sv]
// Shared types and constants for the 3D LUT trilinear color mapper.
package l3d_pkg;

  localparam int GRID_MAX_DEF   = 33;
  localparam int ENTRY_BITS_DEF = 16;

  localparam int CFG_BITS   = 6;
  localparam int IDX_BITS   = 6;
  localparam int FIELD_BITS = 16;
  localparam int PIX_BITS   = 17;
  localparam int FRAC_BITS  = 16;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_BITS-1:0]     GRID_RESET = 6'd33;
  localparam logic [FRAC_BITS:0]      FRAC_ONE   = 17'h10000;

  localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_Z = 2'd2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_MAP   = 1'b1;

  typedef struct packed {
    logic                  cmd;
    logic [IDX_BITS-1:0]   x_index;
    logic [IDX_BITS-1:0]   y_index;
    logic [IDX_BITS-1:0]   z_index;
    logic [FIELD_BITS-1:0] entry_red;
    logic [FIELD_BITS-1:0] entry_green;
    logic [FIELD_BITS-1:0] entry_blue;
    logic [PIX_BITS-1:0]   red_in;
    logic [PIX_BITS-1:0]   green_in;
    logic [PIX_BITS-1:0]   blue_in;
  } l3d_in_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] red_out;
    logic [FIELD_BITS-1:0] green_out;
    logic [FIELD_BITS-1:0] blue_out;
  } l3d_out_t;

  typedef struct packed {
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic [FRAC_BITS-1:0] fz;
  } l3d_frac_t;

endpackage

[design/lut3d_trilinear_color_map_top.sv]
// Top level of the 3D LUT color mapper: node store banks, pipeline and output queue.
//
//  port group  dir  handshake          payload
//  in_         in   in_valid/in_ready  l3d_in_t  (node write or pixel)
//  out_        out  out_valid/out_ready l3d_out_t (mapped pixel)
//  cfg_        in   cfg_we             cfg_index, cfg_data (grid sizes)
//
// One request per clock unless the pipeline holds; each accepted pixel gives one result.
// Eight node banks split by index parity give all eight corners in one read.
// A two-entry output queue keeps input flowing while one result waits.
// Reset clears control and sets all grid sizes to 33; node memory is not cleared.
// The pipeline holds only when the output queue is full and out_ready is low.
module lut3d_trilinear_color_map_top #(
  parameter int GRID_MAX   = l3d_pkg::GRID_MAX_DEF,
  parameter int ENTRY_BITS = l3d_pkg::ENTRY_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  l3d_pkg::l3d_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output l3d_pkg::l3d_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [l3d_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [l3d_pkg::CFG_BITS-1:0]        cfg_data
);

  localparam int GW    = $clog2(GRID_MAX + 1);
  localparam int HB    = GRID_MAX / 2 + 1;
  localparam int HW    = $clog2(HB);
  localparam int DEPTH = HB * HB * HB;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = ENTRY_BITS;
  localparam int NW    = 3 * EW;
  localparam int FB    = l3d_pkg::FRAC_BITS;

  logic [l3d_pkg::CFG_BITS-1:0] grid_x_r, grid_y_r, grid_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_x_r <= l3d_pkg::GRID_RESET;
      grid_y_r <= l3d_pkg::GRID_RESET;
      grid_z_r <= l3d_pkg::GRID_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        l3d_pkg::CFG_GRID_X: grid_x_r <= cfg_data;
        l3d_pkg::CFG_GRID_Y: grid_y_r <= cfg_data;
        l3d_pkg::CFG_GRID_Z: grid_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic advance;
  logic in_fire;

  logic [GW-1:0] lo_x, lo_y, lo_z;
  logic [FB-1:0] fr_x, fr_y, fr_z;
  logic          ok_x, ok_y, ok_z;

  l3d_locate #(.GRID_MAX(GRID_MAX)) u_loc_x (
    .grid(grid_x_r), .pix(in_data.red_in), .idx(in_data.x_index),
    .lo(lo_x), .frac(fr_x), .idx_ok(ok_x)
  );
  l3d_locate #(.GRID_MAX(GRID_MAX)) u_loc_y (
    .grid(grid_y_r), .pix(in_data.green_in), .idx(in_data.y_index),
    .lo(lo_y), .frac(fr_y), .idx_ok(ok_y)
  );
  l3d_locate #(.GRID_MAX(GRID_MAX)) u_loc_z (
    .grid(grid_z_r), .pix(in_data.blue_in), .idx(in_data.z_index),
    .lo(lo_z), .frac(fr_z), .idx_ok(ok_z)
  );

  // Stage 1: located request
  logic               p1_vld_r, p1_cmd_r, p1_wok_r;
  logic [GW-1:0]      p1_wx_r, p1_wy_r, p1_wz_r;
  logic [NW-1:0]      p1_wdata_r;
  logic [GW-1:0]      p1_x0_r, p1_y0_r, p1_z0_r;
  l3d_pkg::l3d_frac_t p1_frac_r;

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (advance) begin
      p1_vld_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p1_cmd_r   <= in_data.cmd;
      p1_wok_r   <= ok_x && ok_y && ok_z;
      p1_wx_r    <= GW'(in_data.x_index);
      p1_wy_r    <= GW'(in_data.y_index);
      p1_wz_r    <= GW'(in_data.z_index);
      p1_wdata_r <= {EW'(in_data.entry_blue), EW'(in_data.entry_green),
                     EW'(in_data.entry_red)};
      p1_x0_r    <= lo_x;
      p1_y0_r    <= lo_y;
      p1_z0_r    <= lo_z;
      p1_frac_r  <= '{fx: fr_x, fy: fr_y, fz: fr_z};
    end
  end

  // Node banks: bank {x[0], y[0], z[0]} holds nodes at half indexes
  logic [AW-1:0] wr_addr;
  logic [2:0]    wr_bank;
  logic          wr_go;
  logic [NW-1:0] bank_q [8];

  assign wr_bank = {p1_wx_r[0], p1_wy_r[0], p1_wz_r[0]};
  assign wr_addr = AW'((int'(p1_wx_r >> 1) * HB + int'(p1_wy_r >> 1)) * HB
                       + int'(p1_wz_r >> 1));
  assign wr_go   = advance && p1_vld_r && (p1_cmd_r == l3d_pkg::CMD_WRITE) && p1_wok_r;

  for (genvar b = 0; b < 8; b++) begin : g_bank
    localparam logic [2:0] BP = 3'(b);
    logic [GW-1:0] sx, sy, sz;
    logic [HW-1:0] hx, hy, hz;
    logic [AW-1:0] rd_addr;

    // Step to the next node where this bank's parity differs from the low corner
    assign sx = p1_x0_r + GW'(p1_x0_r[0] ^ BP[2]);
    assign sy = p1_y0_r + GW'(p1_y0_r[0] ^ BP[1]);
    assign sz = p1_z0_r + GW'(p1_z0_r[0] ^ BP[0]);
    assign hx = HW'(sx >> 1);
    assign hy = HW'(sy >> 1);
    assign hz = HW'(sz >> 1);
    assign rd_addr = AW'((int'(hx) * HB + int'(hy)) * HB + int'(hz));

    l3d_ram #(.WIDTH(NW), .DEPTH(DEPTH)) u_ram (
      .clk(clk),
      .we(wr_go && (wr_bank == BP)),
      .waddr(wr_addr),
      .wdata(p1_wdata_r),
      .re(advance),
      .raddr(rd_addr),
      .rdata(bank_q[b])
    );
  end

  // Stage 2: bank data arrives
  logic               p2_vld_r;
  logic [2:0]         p2_par_r;
  l3d_pkg::l3d_frac_t p2_frac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else if (advance) begin
      p2_vld_r <= p1_vld_r && (p1_cmd_r == l3d_pkg::CMD_MAP);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p2_par_r  <= {p1_x0_r[0], p1_y0_r[0], p1_z0_r[0]};
      p2_frac_r <= p1_frac_r;
    end
  end

  logic              res_vld;
  l3d_pkg::l3d_out_t res;

  l3d_blend #(.ENTRY_BITS(ENTRY_BITS)) u_blend (
    .clk(clk),
    .rst_n(rst_n),
    .advance(advance),
    .in_vld(p2_vld_r),
    .par(p2_par_r),
    .frac(p2_frac_r),
    .bank_data(bank_q),
    .res_vld(res_vld),
    .res(res)
  );

  // Output queue, two entries
  l3d_pkg::l3d_out_t q_r [2];
  logic              q_wp_r, q_rp_r;
  logic [1:0]        q_cnt_r;
  logic              push, pop;

  assign out_valid = (q_cnt_r != 2'd0);
  assign out_data  = q_r[q_rp_r];
  assign pop       = out_valid && out_ready;
  assign advance   = (q_cnt_r != 2'd2) || out_ready;
  assign in_ready  = advance;
  assign push      = advance && res_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= 1'b0;
      q_rp_r  <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      if (push) q_wp_r <= ~q_wp_r;
      if (pop)  q_rp_r <= ~q_rp_r;
      q_cnt_r <= q_cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[q_wp_r] <= res;
    end
  end

endmodule

[design/l3d_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module l3d_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4913,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/l3d_locate.sv]
// One axis: grid size clamp, node index and fraction, write index check.
module l3d_locate #(
  parameter int GRID_MAX = l3d_pkg::GRID_MAX_DEF,
  localparam int GW = $clog2(GRID_MAX + 1)
) (
  input  logic [l3d_pkg::CFG_BITS-1:0]  grid,
  input  logic [l3d_pkg::PIX_BITS-1:0]  pix,
  input  logic [l3d_pkg::IDX_BITS-1:0]  idx,
  output logic [GW-1:0]                 lo,
  output logic [l3d_pkg::FRAC_BITS-1:0] frac,
  output logic                          idx_ok
);

  localparam int PW = l3d_pkg::PIX_BITS + GW;

  logic [GW-1:0] eff;
  logic [GW-1:0] top;
  logic [PW-1:0] prod;
  logic [PW-1:0] lim;

  always_comb begin
    if (int'(grid) < 2) begin
      eff = GW'(2);
    end else if (int'(grid) > GRID_MAX) begin
      eff = GW'(GRID_MAX);
    end else begin
      eff = GW'(grid);
    end
    top  = eff - GW'(1);
    prod = PW'(pix) * PW'(top);
    lim  = PW'(top) << l3d_pkg::FRAC_BITS;
    if (prod >= lim) begin
      lo   = top;
      frac = '0;
    end else begin
      lo   = prod[l3d_pkg::FRAC_BITS +: GW];
      frac = prod[l3d_pkg::FRAC_BITS-1:0];
    end
    idx_ok = int'(idx) < int'(eff);
  end

endmodule

[design/l3d_blend.sv]
// Trilinear blend pipeline: red-axis, green-axis and blue-axis lerp stages.
module l3d_blend #(
  parameter int ENTRY_BITS = l3d_pkg::ENTRY_BITS_DEF,
  localparam int NW = 3 * ENTRY_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic                in_vld,
  input  logic [2:0]          par,
  input  l3d_pkg::l3d_frac_t  frac,
  input  logic [NW-1:0]       bank_data [8],
  output logic                res_vld,
  output l3d_pkg::l3d_out_t   res
);

  localparam int EW = ENTRY_BITS;
  localparam int AW = EW + 16;
  localparam int BW = EW + 33;
  localparam int FB = l3d_pkg::FRAC_BITS;

  // a: [channel][y corner][z corner]; b: [channel][z corner]
  logic [AW-1:0]  a_nxt [3][2][2];
  logic [AW-1:0]  a_r   [3][2][2];
  logic [AW-1:0]  b_nxt [3][2];
  logic [AW-1:0]  b_r   [3][2];
  logic [FB-1:0]  fy_r, fz_r, fz2_r;
  logic           s3_vld_r, s4_vld_r, s5_vld_r;
  logic [FB-1:0]  out_nxt [3];
  logic [FB-1:0]  out_r   [3];

  always_comb begin
    logic [FB:0]    wx_lo, wy_lo, wz_lo;
    logic [EW-1:0]  c0, c1;
    logic [AW:0]    asum;
    logic [BW-1:0]  bsum;
    logic [BW-1:0]  rsum;
    logic           xs, ys, zs;
    wx_lo = l3d_pkg::FRAC_ONE - {1'b0, frac.fx};
    wy_lo = l3d_pkg::FRAC_ONE - {1'b0, fy_r};
    wz_lo = l3d_pkg::FRAC_ONE - {1'b0, fz2_r};
    // With a zero fraction the upper corner has no weight: reuse the lower one,
    // so a clamped top node never pulls in a node past the grid
    xs = (frac.fx != '0);
    ys = (frac.fy != '0);
    zs = (frac.fz != '0);
    for (int ch = 0; ch < 3; ch++) begin
      for (int j = 0; j < 2; j++) begin
        for (int k = 0; k < 2; k++) begin
          c0 = bank_data[{par[2], par[1] ^ (j[0] & ys), par[0] ^ (k[0] & zs)}][ch*EW +: EW];
          c1 = bank_data[{par[2] ^ xs, par[1] ^ (j[0] & ys), par[0] ^ (k[0] & zs)}]
                        [ch*EW +: EW];
          asum = (AW+1)'(c0) * (AW+1)'(wx_lo) + (AW+1)'(c1) * (AW+1)'(frac.fx);
          a_nxt[ch][j][k] = asum[AW-1:0];
        end
      end
      for (int k = 0; k < 2; k++) begin
        bsum = BW'(a_r[ch][0][k]) * BW'(wy_lo) + BW'(a_r[ch][1][k]) * BW'(fy_r)
             + BW'(33'h8000);
        b_nxt[ch][k] = bsum[FB +: AW];
      end
      rsum = BW'(b_r[ch][0]) * BW'(wz_lo) + BW'(b_r[ch][1]) * BW'(fz2_r)
           + BW'(33'h80000000);
      out_nxt[ch] = 16'(rsum >> 32);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else if (advance) begin
      s3_vld_r <= in_vld;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_r   <= a_nxt;
      fy_r  <= frac.fy;
      fz_r  <= frac.fz;
      b_r   <= b_nxt;
      fz2_r <= fz_r;
      out_r <= out_nxt;
    end
  end

  assign res_vld       = s5_vld_r;
  assign res.red_out   = out_r[0];
  assign res.green_out = out_r[1];
  assign res.blue_out  = out_r[2];

endmodule

[tb/tb_lut3d_trilinear_color_map_top.sv]
// Self-checking testbench for the 3D LUT trilinear color mapper.
`timescale 1ns / 1ps

module tb_lut3d_trilinear_color_map_top;

  localparam int GMAX  = l3d_pkg::GRID_MAX_DEF;
  localparam int NODES = GMAX * GMAX * GMAX;
  // Nodes 0..FILL-1 on every axis are written before any pixel is mapped
  localparam int FILL  = 6;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  l3d_pkg::l3d_in_t            in_data;
  logic                        out_valid;
  logic                        out_ready;
  l3d_pkg::l3d_out_t           out_data;
  logic                        cfg_we;
  logic [l3d_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [l3d_pkg::CFG_BITS-1:0]     cfg_data;

  lut3d_trilinear_color_map_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  l3d_pkg::l3d_in_t   request_q[$];
  l3d_pkg::l3d_out_t  pixel_exp_q[$];
  logic [47:0] node_mem[NODES];
  logic [l3d_pkg::CFG_BITS-1:0] grid_reg[3];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_trig = 0;
  int hold_seen = 0;
  int hold_cnt = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int eff_size(logic [l3d_pkg::CFG_BITS-1:0] g);
    if (g < 2) return 2;
    if (g > GMAX) return GMAX;
    return int'(g);
  endfunction

  function automatic int node_at(int x, int y, int z);
    return (x * GMAX + y) * GMAX + z;
  endfunction

  // Split a UQ1.16 channel into lower node, upper node and fraction.
  function automatic void find_cell(logic [l3d_pkg::PIX_BITS-1:0] pix, int g,
                                    output int lo, output int hi,
                                    output longint unsigned fr);
    longint unsigned top, p;
    top = g - 1;
    p = longint'(pix) * top;
    if (p >= (top << 16)) begin
      lo = int'(top);
      fr = 0;
    end else begin
      lo = int'(p >> 16);
      fr = p & 64'hFFFF;
    end
    hi = (lo + 1 < int'(top)) ? lo + 1 : int'(top);
  endfunction

  function automatic longint unsigned blend(longint unsigned a, longint unsigned b,
                                            longint unsigned f);
    return a * (65536 - f) + b * f;
  endfunction

  function automatic l3d_pkg::l3d_out_t map_pixel(l3d_pkg::l3d_in_t px);
    int x0, x1, y0, y1, z0, z1, sh;
    longint unsigned fx, fy, fz, a0, a1, zr0, zr1, r;
    logic [15:0] ch[3];
    find_cell(px.red_in, eff_size(grid_reg[l3d_pkg::CFG_GRID_X]), x0, x1, fx);
    find_cell(px.green_in, eff_size(grid_reg[l3d_pkg::CFG_GRID_Y]), y0, y1, fy);
    find_cell(px.blue_in, eff_size(grid_reg[l3d_pkg::CFG_GRID_Z]), z0, z1, fz);
    for (int c = 0; c < 3; c++) begin
      sh = 32 - 16 * c;
      a0 = blend(node_mem[node_at(x0, y0, z0)][sh +: 16],
                 node_mem[node_at(x1, y0, z0)][sh +: 16], fx);
      a1 = blend(node_mem[node_at(x0, y1, z0)][sh +: 16],
                 node_mem[node_at(x1, y1, z0)][sh +: 16], fx);
      zr0 = (blend(a0, a1, fy) + 32768) >> 16;
      a0 = blend(node_mem[node_at(x0, y0, z1)][sh +: 16],
                 node_mem[node_at(x1, y0, z1)][sh +: 16], fx);
      a1 = blend(node_mem[node_at(x0, y1, z1)][sh +: 16],
                 node_mem[node_at(x1, y1, z1)][sh +: 16], fx);
      zr1 = (blend(a0, a1, fy) + 32768) >> 16;
      r = (blend(zr0, zr1, fz) + 64'h8000_0000) >> 32;
      ch[c] = r[15:0];
    end
    return '{red_out: ch[0], green_out: ch[1], blue_out: ch[2]};
  endfunction

  // Track config and requests; queue the expected pixel for each map.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) grid_reg[cfg_index] = cfg_data;
      if (in_valid && in_ready) begin
        if (in_data.cmd == l3d_pkg::CMD_MAP) begin
          pixel_exp_q.push_back(map_pixel(in_data));
        end else if (in_data.x_index < eff_size(grid_reg[l3d_pkg::CFG_GRID_X]) &&
                     in_data.y_index < eff_size(grid_reg[l3d_pkg::CFG_GRID_Y]) &&
                     in_data.z_index < eff_size(grid_reg[l3d_pkg::CFG_GRID_Z])) begin
          node_mem[node_at(in_data.x_index, in_data.y_index, in_data.z_index)] =
            {in_data.entry_red, in_data.entry_green, in_data.entry_blue};
        end
      end
      if (out_valid && out_ready) begin
        if (pixel_exp_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel, expected none, actual %h", $time, out_data);
        end else begin
          l3d_pkg::l3d_out_t e;
          e = pixel_exp_q.pop_front();
          if (out_data.red_out !== e.red_out) begin
            errors++;
            $display("%0t: red_out expected %h actual %h", $time, e.red_out, out_data.red_out);
          end
          if (out_data.green_out !== e.green_out) begin
            errors++;
            $display("%0t: green_out expected %h actual %h", $time, e.green_out,
                     out_data.green_out);
          end
          if (out_data.blue_out !== e.blue_out) begin
            errors++;
            $display("%0t: blue_out expected %h actual %h", $time, e.blue_out,
                     out_data.blue_out);
          end
        end
      end
    end
  end

  // Driver: hold the request until accepted, then advance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= request_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_trig != hold_seen) begin
      hold_seen = hold_trig;
      hold_cnt = 300;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_grid(logic [l3d_pkg::CFG_IDX_BITS-1:0] idx,
                            logic [l3d_pkg::CFG_BITS-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (request_q.size() > 0 || in_valid || pixel_exp_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic l3d_pkg::l3d_in_t node_write(int x, int y, int z, logic [15:0] r,
                                                  logic [15:0] g, logic [15:0] b);
    l3d_pkg::l3d_in_t t;
    t = l3d_pkg::l3d_in_t'($bits(l3d_pkg::l3d_in_t)'({$urandom, $urandom, $urandom,
                                                      $urandom}));
    t.cmd = l3d_pkg::CMD_WRITE;
    t.x_index = l3d_pkg::IDX_BITS'(x);
    t.y_index = l3d_pkg::IDX_BITS'(y);
    t.z_index = l3d_pkg::IDX_BITS'(z);
    t.entry_red = r; t.entry_green = g; t.entry_blue = b;
    return t;
  endfunction

  // Random pixel channel; on a grid finer than the filled block keep reads inside it.
  function automatic logic [l3d_pkg::PIX_BITS-1:0] rand_pix(int g);
    int k;
    int lim;
    k = $urandom_range(9);
    if (g <= FILL) begin
      if (k < 6) return l3d_pkg::PIX_BITS'($urandom_range(65536));
      if (k == 6) return 17'h10000;
      if (k == 7) return 17'h0;
      return l3d_pkg::PIX_BITS'($urandom);
    end
    lim = ((FILL - 1) * 65536 - 1) / (g - 1);
    if (k == 7) return 17'h0;
    return l3d_pkg::PIX_BITS'($urandom_range(lim));
  endfunction

  function automatic l3d_pkg::l3d_in_t pixel_req(logic [l3d_pkg::PIX_BITS-1:0] r,
                                                 logic [l3d_pkg::PIX_BITS-1:0] g,
                                                 logic [l3d_pkg::PIX_BITS-1:0] b);
    l3d_pkg::l3d_in_t t;
    t = l3d_pkg::l3d_in_t'($bits(l3d_pkg::l3d_in_t)'({$urandom, $urandom, $urandom,
                                                      $urandom}));
    t.cmd = l3d_pkg::CMD_MAP;
    t.red_in = r; t.green_in = g; t.blue_in = b;
    return t;
  endfunction

  task automatic random_burst(int n, int gx, int gy, int gz);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 70) begin
        request_q.push_back(pixel_req(rand_pix(gx), rand_pix(gy), rand_pix(gz)));
      end else if ($urandom_range(9) == 0) begin
        request_q.push_back(node_write($urandom_range(63), $urandom_range(63),
                                       $urandom_range(63), 16'($urandom), 16'($urandom),
                                       16'($urandom)));
      end else begin
        request_q.push_back(node_write($urandom_range(32), $urandom_range(32),
                                       $urandom_range(32), 16'($urandom), 16'($urandom),
                                       16'($urandom)));
      end
    end
  endtask

  initial begin
    logic [l3d_pkg::CFG_BITS-1:0] grids[8][3];
    int send_mode[8], recv_mode[8];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = l3d_pkg::CFG_GRID_X;
    cfg_data = '0;
    for (int i = 0; i < 3; i++) grid_reg[i] = l3d_pkg::GRID_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    write_grid(l3d_pkg::CFG_GRID_X, 6'd33);
    write_grid(l3d_pkg::CFG_GRID_Y, 6'd33);
    write_grid(l3d_pkg::CFG_GRID_Z, 6'd33);

    // Fill the low block of nodes first so no later map reads an unwritten entry.
    for (int x = 0; x < FILL; x++)
      for (int y = 0; y < FILL; y++)
        for (int z = 0; z < FILL; z++)
          request_q.push_back(node_write(x, y, z, 16'($urandom), 16'($urandom),
                                         16'($urandom)));
    drain();

    // Directed: extreme entries, ignored writes, edge pixels on a grid of FILL.
    write_grid(l3d_pkg::CFG_GRID_X, 6'(FILL));
    write_grid(l3d_pkg::CFG_GRID_Y, 6'(FILL));
    write_grid(l3d_pkg::CFG_GRID_Z, 6'(FILL));
    request_q.push_back(node_write(0, 0, 0, 16'h0000, 16'hFFFF, 16'h0000));
    request_q.push_back(node_write(32, 32, 32, 16'hFFFF, 16'h0000, 16'hFFFF));
    request_q.push_back(node_write(33, 0, 0, 16'h1234, 16'h1234, 16'h1234));
    request_q.push_back(node_write(0, 63, 0, 16'h1234, 16'h1234, 16'h1234));
    request_q.push_back(node_write(0, 0, 40, 16'h1234, 16'h1234, 16'h1234));
    request_q.push_back(pixel_req(17'h0, 17'h0, 17'h0));
    request_q.push_back(pixel_req(17'h10000, 17'h10000, 17'h10000));
    request_q.push_back(pixel_req(17'h0FFFF, 17'h0FFFF, 17'h0FFFF));
    request_q.push_back(pixel_req(17'h1FFFF, 17'h1FFFF, 17'h1FFFF));
    request_q.push_back(pixel_req(17'h0, 17'h10000, 17'h1FFFF));
    request_q.push_back(pixel_req(17'h08000, 17'h00001, 17'h0FFFF));
    request_q.push_back(pixel_req(17'h10001, 17'h0, 17'h08000));
    drain();

    grids = '{'{33, 33, 33}, '{2, 2, 2}, '{0, 1, 63}, '{5, 17, 9},
              '{33, 2, 34}, '{3, 33, 7}, '{60, 12, 2}, '{33, 33, 33}};
    send_mode = '{0, 54, 0, 54, 7, 0, 54, 7};
    recv_mode = '{0, 0, 54, 54, 7, 0, 54, 7};
    for (int ph = 0; ph < 8; ph++) begin
      write_grid(l3d_pkg::CFG_GRID_X, grids[ph][0]);
      write_grid(l3d_pkg::CFG_GRID_Y, grids[ph][1]);
      write_grid(l3d_pkg::CFG_GRID_Z, grids[ph][2]);
      send_idle_pct = send_mode[ph];
      recv_idle_pct = recv_mode[ph];
      if (ph == 5) hold_trig++;
      random_burst(ph == 5 ? 60 : 95, eff_size(grids[ph][0]), eff_size(grids[ph][1]),
                   eff_size(grids[ph][2]));
      drain();
    end

    if (pixel_exp_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("** lut3d_trilinear_color_map_top: PASSED **");
    end else begin
      $display("** lut3d_trilinear_color_map_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("** lut3d_trilinear_color_map_top: FAILED **");
    $finish;
  end

endmodule
